// ===== hdl/rms_level_meter_assert.svh =====
// assertion macros shared by the rms level meter modules
`ifndef RMS_LEVEL_METER_ASSERT_SVH
`define RMS_LEVEL_METER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define RLM_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RLM_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define RLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rlm_pkg.sv =====
// shared constants and types of the rms level meter
`timescale 1ns / 1ps
package rlm_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned SquareW = 31;
  localparam int unsigned LevelW = 7;
  localparam int unsigned MulW = 22;
  localparam int unsigned ScaleW = 14;
  localparam int unsigned FullScaleShift = 15;

  localparam logic [LevelW-1:0] LevelTop = 7'd100;
  localparam logic [ScaleW-1:0] LevelScale = 14'd10000;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQ   = 5'b00010,
    ST_LO   = 5'b00100,
    ST_HI   = 5'b01000,
    ST_CMP  = 5'b10000
  } back_state_e;

endpackage

// ===== hdl/rms_level_meter.sv =====
// top level of the rms level meter
`timescale 1ns / 1ps
// Measures the RMS level of buffers of signed 16-bit samples as a percentage
// of full scale (0 to 100, truncated), one result per buffer on the sample
// marked last, with a flag when more than MAX_SAMPLES samples arrived and the
// surplus was dropped. Samples are taken one per cycle while the queue has
// room; the front end squares and accumulates them, then hands each
// finished buffer total to a two-entry queue. The back end finds the level
// by a binary search of six or seven probes through the square, low, high
// and compare states on one shared 22x22 multiplier, and takes the next
// total once the last level is in the output register. Buffers shorter
// than the back end's search stall the sample input once the queue fills.
module rms_level_meter #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [rlm_pkg::SampleW-1:0] sample_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rlm_pkg::LevelW-1:0]         level_o,
  output logic                               overflowed_o
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SumW = rlm_pkg::SquareW - 1 + CntW;
  localparam int unsigned EntW = SumW + CntW + 1;

  logic            push_valid, push_ready, pop_valid, pop_ready;
  logic [EntW-1:0] push_data, pop_data;

  rlm_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .last_i       (last_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rlm_queue #(
    .W (EntW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rlm_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .level_o      (level_o),
    .overflowed_o (overflowed_o)
  );

endmodule

// ===== hdl/rlm_queue.sv =====
// two-entry queue of finished buffer totals between front and back
`timescale 1ns / 1ps
module rlm_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  localparam logic [1:0] Full = 2'd2;

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   fill_q, fill_d;
  logic         push, pop;

  always_comb begin
    push_ready_o = (fill_q != Full);
    pop_valid_o  = (fill_q != 2'd0);
    pop_data_o   = mem_q[rd_ptr_q];
    push         = push_valid_i & push_ready_o;
    pop          = pop_valid_o & pop_ready_i;
    wr_ptr_d     = wr_ptr_q ^ push;
    rd_ptr_d     = rd_ptr_q ^ pop;
    fill_d       = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/rlm_front.sv =====
// front end: takes samples, squares them and accumulates per buffer
`timescale 1ns / 1ps
`include "rms_level_meter_assert.svh"
module rlm_front #(
  parameter int unsigned MAX_SAMPLES = 4096,
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned SumW = rlm_pkg::SquareW - 1 + CntW,
  localparam int unsigned EntW = SumW + CntW + 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [rlm_pkg::SampleW-1:0] sample_i,
  input  logic                              last_i,
  output logic                              push_valid_o,
  input  logic                              push_ready_i,
  output logic [EntW-1:0]                   push_data_o
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SAMPLES);

  logic [rlm_pkg::SampleW-1:0]   raw, mag;
  logic [2*rlm_pkg::SampleW-1:0] prod;
  logic                          in_room, accept, a_retire;
  logic [SumW-1:0]               sum_next;

  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          drop_q, drop_d;
  logic [SumW-1:0]               sum_q, sum_d;
  logic                          a_valid_q, a_valid_d;
  logic                          a_last_q, a_last_d;
  logic [rlm_pkg::SquareW-1:0]   a_sq_q, a_sq_d;
  logic [CntW-1:0]               a_cnt_q, a_cnt_d;
  logic                          a_drop_q, a_drop_d;

  always_comb begin
    raw      = sample_i;
    mag      = raw[rlm_pkg::SampleW-1] ? (~raw + 16'd1) : raw;
    prod     = mag * mag;
    in_room  = (cnt_q < MaxCnt);
    a_retire = a_valid_q & (!a_last_q | push_ready_i);
    in_ready_o = !a_valid_q | a_retire;
    accept   = in_valid_i & in_ready_o;
    sum_next = sum_q + SumW'(a_sq_q);

    cnt_d     = cnt_q;
    drop_d    = drop_q;
    a_valid_d = a_valid_q;
    a_last_d  = a_last_q;
    a_sq_d    = a_sq_q;
    a_cnt_d   = a_cnt_q;
    a_drop_d  = a_drop_q;
    sum_d     = sum_q;

    if (accept) begin
      a_valid_d = 1'b1;
      a_last_d  = last_i;
      a_sq_d    = in_room ? prod[rlm_pkg::SquareW-1:0] : '0;
      a_cnt_d   = in_room ? cnt_q + 1'b1 : cnt_q;
      a_drop_d  = drop_q | !in_room;
      if (last_i) begin
        cnt_d  = '0;
        drop_d = 1'b0;
      end else begin
        cnt_d  = in_room ? cnt_q + 1'b1 : cnt_q;
        drop_d = drop_q | !in_room;
      end
    end else if (a_retire) begin
      a_valid_d = 1'b0;
    end

    if (a_retire) begin
      sum_d = a_last_q ? '0 : sum_next;
    end

    push_valid_o = a_valid_q & a_last_q;
    push_data_o  = {sum_next, a_cnt_q, a_drop_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      drop_q    <= 1'b0;
      sum_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      drop_q    <= drop_d;
      sum_q     <= sum_d;
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_last_q <= a_last_d;
    a_sq_q   <= a_sq_d;
    a_cnt_q  <= a_cnt_d;
    a_drop_q <= a_drop_d;
  end

  `RLM_ASSERT_HOLDS(a_cnt_bound, cnt_q <= MaxCnt, "sample count beyond limit")
  `RLM_ASSERT_IMPLIES(a_stall_cause, !in_ready_o, a_valid_q && a_last_q && !push_ready_i, "front stalled without a full queue")
  `RLM_ASSERT_NEXT(a_stage_holds, a_valid_q && !a_retire, a_valid_q && $stable(a_cnt_q), "held square stage lost")

endmodule

// ===== hdl/rlm_back.sv =====
// back end: binary search of the level over a shared multiplier
`timescale 1ns / 1ps
`include "rms_level_meter_assert.svh"
module rlm_back #(
  parameter int unsigned MAX_SAMPLES = 4096,
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned SumW = rlm_pkg::SquareW - 1 + CntW,
  localparam int unsigned EntW = SumW + CntW + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  logic [EntW-1:0]             pop_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rlm_pkg::LevelW-1:0]  level_o,
  output logic                        overflowed_o
);

  localparam int unsigned MulW = rlm_pkg::MulW;
  localparam int unsigned CmpW = SumW + rlm_pkg::ScaleW;
  localparam int unsigned LvW  = rlm_pkg::LevelW;

  rlm_pkg::back_state_e state_q, state_d;

  logic [CmpW-1:0]   lhs_q, lhs_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              drop_q, drop_d;
  logic [LvW-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [2*MulW-1:0] a2_q, a2_d, p_lo_q, p_lo_d, p_hi_q, p_hi_d;
  logic              out_valid_q, out_valid_d;
  logic [LvW-1:0]    level_q, level_d;
  logic              ovf_q, ovf_d;

  logic [SumW-1:0]   ent_sum;
  logic [CntW-1:0]   ent_cnt;
  logic              ent_drop;
  logic [LvW:0]      mid_sum;
  logic [LvW-1:0]    mid, lo_n, hi_n;
  logic [MulW-1:0]   scaled, cnt_ext, mul_a, mul_b;
  logic [2*MulW-1:0] product;
  logic [3*MulW-1:0] rhs_wide;
  logic              fits, out_free, pop;

  always_comb begin
    ent_sum  = pop_data_i[EntW-1 -: SumW];
    ent_cnt  = pop_data_i[CntW:1];
    ent_drop = pop_data_i[0];
    mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} + 8'd1;
    mid      = mid_sum[LvW:1];
    // full scale is 2^15 - 1
    scaled   = (MulW'(mid) << rlm_pkg::FullScaleShift) - MulW'(mid);
    cnt_ext  = MulW'(cnt_q);

    unique case (state_q)
      rlm_pkg::ST_SQ: begin
        mul_a = scaled;
        mul_b = scaled;
      end
      rlm_pkg::ST_LO: begin
        mul_a = cnt_ext;
        mul_b = a2_q[MulW-1:0];
      end
      rlm_pkg::ST_HI: begin
        mul_a = cnt_ext;
        mul_b = a2_q[2*MulW-1:MulW];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    product  = mul_a * mul_b;

    rhs_wide = {p_hi_q, MulW'(0)} + (3*MulW)'(p_lo_q);
    fits     = (lhs_q >= rhs_wide[CmpW-1:0]);
    lo_n     = fits ? mid : lo_q;
    hi_n     = fits ? hi_q : mid - 1'b1;

    out_free    = !out_valid_q | out_ready_i;
    pop_ready_o = (state_q == rlm_pkg::ST_IDLE);
    pop         = pop_valid_i & pop_ready_o;

    state_d     = state_q;
    lhs_d       = lhs_q;
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    a2_d        = a2_q;
    p_lo_d      = p_lo_q;
    p_hi_d      = p_hi_q;
    out_valid_d = out_valid_q & !out_ready_i;
    level_d     = level_q;
    ovf_d       = ovf_q;

    unique case (state_q)
      rlm_pkg::ST_IDLE: begin
        if (pop) begin
          lhs_d   = CmpW'(ent_sum) * CmpW'(rlm_pkg::LevelScale);
          cnt_d   = ent_cnt;
          drop_d  = ent_drop;
          lo_d    = '0;
          hi_d    = rlm_pkg::LevelTop;
          state_d = rlm_pkg::ST_SQ;
        end
      end
      rlm_pkg::ST_SQ: begin
        a2_d    = product;
        state_d = rlm_pkg::ST_LO;
      end
      rlm_pkg::ST_LO: begin
        p_lo_d  = product;
        state_d = rlm_pkg::ST_HI;
      end
      rlm_pkg::ST_HI: begin
        p_hi_d  = product;
        state_d = rlm_pkg::ST_CMP;
      end
      rlm_pkg::ST_CMP: begin
        if (lo_n != hi_n) begin
          lo_d    = lo_n;
          hi_d    = hi_n;
          state_d = rlm_pkg::ST_SQ;
        end else if (out_free) begin
          lo_d        = lo_n;
          hi_d        = hi_n;
          out_valid_d = 1'b1;
          level_d     = (cnt_q == '0) ? '0 : lo_n;
          ovf_d       = drop_q;
          state_d     = rlm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rlm_pkg::ST_IDLE;
      end
    endcase

    out_valid_o  = out_valid_q;
    level_o      = level_q;
    overflowed_o = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lhs_q   <= lhs_d;
    cnt_q   <= cnt_d;
    drop_q  <= drop_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    a2_q    <= a2_d;
    p_lo_q  <= p_lo_d;
    p_hi_q  <= p_hi_d;
    level_q <= level_d;
    ovf_q   <= ovf_d;
  end

  `RLM_ASSERT_IMPLIES(a_search_open, state_q == rlm_pkg::ST_SQ, lo_q < hi_q, "search range empty")
  `RLM_ASSERT_IMPLIES(a_level_bound, out_valid_q, level_q <= rlm_pkg::LevelTop, "level above full scale")
  `RLM_ASSERT_NEXT(a_result_kept, out_valid_q && !out_ready_i, out_valid_q && $stable(level_q), "pending level lost")

endmodule
